>>> sv/fcct_pkg.sv
package fcct_pkg;

  // field widths
  localparam int TIME_W  = 63;
  localparam int OP_W    = 2;
  localparam int CHIP_W  = 6;
  localparam int COUNT_W = 5;
  localparam int DLY_W   = 32;

  // APB
  localparam int APB_AW  = 5;
  localparam int APB_DW  = 32;
  localparam int REG_W   = 3;

  // default sizes of the time stores
  localparam int DEF_MAX_CHANNELS = 16;
  localparam int DEF_MAX_CHIPS    = 64;

  // operation codes
  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_ERASE = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

  // register indexes (byte address / 4)
  localparam logic [REG_W-1:0] REG_CHANNEL_COUNT = 3'd0;
  localparam logic [REG_W-1:0] REG_WRITE_XFER    = 3'd1;
  localparam logic [REG_W-1:0] REG_PROGRAM       = 3'd2;
  localparam logic [REG_W-1:0] REG_CELL_READ     = 3'd3;
  localparam logic [REG_W-1:0] REG_READ_XFER     = 3'd4;
  localparam logic [REG_W-1:0] REG_ERASE         = 3'd5;

  // reset values
  localparam logic [COUNT_W-1:0] RST_CHANNEL_COUNT = 5'd8;
  localparam logic [DLY_W-1:0]   RST_WRITE_XFER    = 32'd40000;
  localparam logic [DLY_W-1:0]   RST_PROGRAM       = 32'd800000;
  localparam logic [DLY_W-1:0]   RST_CELL_READ     = 32'd60000;
  localparam logic [DLY_W-1:0]   RST_READ_XFER     = 32'd40000;
  localparam logic [DLY_W-1:0]   RST_ERASE         = 32'd3000000;

  typedef struct packed {
    logic [COUNT_W-1:0] channel_count;
    logic [DLY_W-1:0]   wr_xfer_dly;
    logic [DLY_W-1:0]   prog_dly;
    logic [DLY_W-1:0]   cell_rd_dly;
    logic [DLY_W-1:0]   rd_xfer_dly;
    logic [DLY_W-1:0]   erase_dly;
  } cfg_t;

  typedef struct packed {
    logic clear;     // clearing sweep step
    logic accept;    // latch command, start channel remainder
    logic div_step;  // one remainder bit
    logic rd;        // read both stores
    logic calc1;     // first reservation
    logic calc2;     // second reservation
    logic wb;        // write back, form wait
    logic load_out;  // move wait into output register
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_last;
  } sts_t;

endpackage

>>> sv/fcct_regs.sv
module fcct_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fcct_pkg::APB_AW-1:0]   paddr,
  input  logic [fcct_pkg::APB_DW-1:0]   pwdata,
  output logic [fcct_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output fcct_pkg::cfg_t                cfg
);

  logic                         wr_en;
  logic [fcct_pkg::REG_W-1:0]   reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[fcct_pkg::APB_AW-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_count <= fcct_pkg::RST_CHANNEL_COUNT;
      cfg.wr_xfer_dly   <= fcct_pkg::RST_WRITE_XFER;
      cfg.prog_dly      <= fcct_pkg::RST_PROGRAM;
      cfg.cell_rd_dly   <= fcct_pkg::RST_CELL_READ;
      cfg.rd_xfer_dly   <= fcct_pkg::RST_READ_XFER;
      cfg.erase_dly     <= fcct_pkg::RST_ERASE;
    end else if (wr_en) begin
      case (reg_sel)
        fcct_pkg::REG_CHANNEL_COUNT:
          cfg.channel_count <= pwdata[fcct_pkg::COUNT_W-1:0];
        fcct_pkg::REG_WRITE_XFER: cfg.wr_xfer_dly <= pwdata;
        fcct_pkg::REG_PROGRAM:    cfg.prog_dly    <= pwdata;
        fcct_pkg::REG_CELL_READ:  cfg.cell_rd_dly <= pwdata;
        fcct_pkg::REG_READ_XFER:  cfg.rd_xfer_dly <= pwdata;
        fcct_pkg::REG_ERASE:      cfg.erase_dly   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      fcct_pkg::REG_CHANNEL_COUNT:
        prdata = {{(fcct_pkg::APB_DW-fcct_pkg::COUNT_W){1'b0}}, cfg.channel_count};
      fcct_pkg::REG_WRITE_XFER: prdata = cfg.wr_xfer_dly;
      fcct_pkg::REG_PROGRAM:    prdata = cfg.prog_dly;
      fcct_pkg::REG_CELL_READ:  prdata = cfg.cell_rd_dly;
      fcct_pkg::REG_READ_XFER:  prdata = cfg.rd_xfer_dly;
      fcct_pkg::REG_ERASE:      prdata = cfg.erase_dly;
      default:                  prdata = '0;
    endcase
  end

endmodule

>>> sv/fcct_ctrl.sv
module fcct_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  fcct_pkg::sts_t  sts,
  output fcct_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CALC1 = 3'd4;
  localparam logic [2:0] S_CALC2 = 3'd5;
  localparam logic [2:0] S_WB    = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = ~out_valid | ~out_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_READ;
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_CALC1;
      end
      S_CALC1: begin
        cmd.calc1  = 1'b1;
        state_next = S_CALC2;
      end
      S_CALC2: begin
        cmd.calc2  = 1'b1;
        state_next = S_WB;
      end
      S_WB: begin
        cmd.wb     = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out)
        out_valid <= 1'b1;
      else if (~out_stall)
        out_valid <= 1'b0;
    end
  end

endmodule

>>> sv/fcct_dpath.sv
module fcct_dpath #(
  parameter int MAX_CHANNELS = fcct_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_CHIPS    = fcct_pkg::DEF_MAX_CHIPS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  fcct_pkg::cfg_t                cfg,
  input  fcct_pkg::cmd_t                cmd,
  output fcct_pkg::sts_t                sts,
  input  logic [fcct_pkg::OP_W-1:0]     operation,
  input  logic [fcct_pkg::CHIP_W-1:0]   chip_index,
  input  logic [fcct_pkg::TIME_W-1:0]   now_time,
  output logic [fcct_pkg::TIME_W-1:0]   wait_time
);

  localparam int TW     = fcct_pkg::TIME_W;
  localparam int CW     = fcct_pkg::CHIP_W;
  localparam int NW     = fcct_pkg::COUNT_W;
  localparam int CH_AW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CP_AW  = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1;
  localparam int CLR_N  = (MAX_CHANNELS > MAX_CHIPS) ? MAX_CHANNELS : MAX_CHIPS;
  localparam int CLR_AW = (CLR_N > 1) ? $clog2(CLR_N) : 1;
  localparam int DIV_W  = $clog2(CW);
  localparam logic [CW:0] CHIP_DIV = (CW+1)'(MAX_CHIPS);

  // chip_index mod MAX_CHIPS by compare-subtract, one step per index bit
  function automatic logic [CW-1:0] chip_wrap(input logic [CW-1:0] c);
    logic [CW:0] r;
    r = '0;
    if (MAX_CHIPS >= (1 << CW)) begin
      r = {1'b0, c};
    end else begin
      for (int i = CW - 1; i >= 0; i--) begin
        r = {r[CW-1:0], c[i]};
        if (r >= CHIP_DIV) r = r - CHIP_DIV;
      end
    end
    return r[CW-1:0];
  endfunction

  function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a,
                                            input logic [TW-1:0] b);
    logic [TW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TW] ? {TW{1'b1}} : s[TW-1:0];
  endfunction

  logic [TW-1:0] chan_mem [MAX_CHANNELS];
  logic [TW-1:0] chip_mem [MAX_CHIPS];

  logic [fcct_pkg::OP_W-1:0] op_r;
  logic [TW-1:0]             now_r;
  logic [CP_AW-1:0]          cp_r;
  logic [NW-1:0]             dvs;
  logic [NW-1:0]             rem;
  logic [CW-1:0]             sh;
  logic [DIV_W-1:0]          div_cnt;
  logic [CLR_AW-1:0]         clr_idx;
  logic [TW-1:0]             ch_rdata;
  logic [TW-1:0]             cp_rdata;
  logic [TW-1:0]             t1;
  logic [TW-1:0]             t2;
  logic [TW-1:0]             res;

  logic [NW-1:0]    nch;
  logic [NW:0]      trial;
  logic [CH_AW-1:0] ch_addr;
  logic             is_rd;
  logic             is_wr;
  logic             is_er;
  logic [TW-1:0]    x1;
  logic [TW-1:0]    a1;
  logic [TW-1:0]    d1;
  logic [TW-1:0]    y2;
  logic [TW-1:0]    b2;
  logic [TW-1:0]    d2;
  logic             ch_we;
  logic [CH_AW-1:0] ch_wa;
  logic [TW-1:0]    ch_wd;
  logic             cp_we;
  logic [CP_AW-1:0] cp_wa;
  logic [TW-1:0]    cp_wd;

  // effective channel count: zero reads as one, capped at the store depth
  always_comb begin
    if (cfg.channel_count == '0)
      nch = NW'(1);
    else if (int'(cfg.channel_count) > MAX_CHANNELS)
      nch = NW'(MAX_CHANNELS);
    else
      nch = cfg.channel_count;
  end

  assign trial   = {rem, sh[CW-1]};
  assign ch_addr = CH_AW'(rem);
  assign is_rd   = (op_r == fcct_pkg::OP_READ);
  assign is_wr   = (op_r == fcct_pkg::OP_WRITE);
  assign is_er   = (op_r == fcct_pkg::OP_ERASE);

  assign sts.div_last = (div_cnt == DIV_W'(CW - 1));
  assign sts.clr_last = (clr_idx == CLR_AW'(CLR_N - 1));

  // first reservation: read takes the chip, write and erase look at the channel
  always_comb begin
    x1 = is_rd ? cp_rdata : ch_rdata;
    a1 = (x1 > now_r) ? x1 : now_r;
    if (is_rd)      d1 = TW'(cfg.cell_rd_dly);
    else if (is_wr) d1 = TW'(cfg.wr_xfer_dly);
    else            d1 = '0;
  end

  // second reservation: read takes the channel, write and erase the chip
  always_comb begin
    y2 = is_rd ? ch_rdata : cp_rdata;
    b2 = (y2 > t1) ? y2 : t1;
    if (is_rd)      d2 = TW'(cfg.rd_xfer_dly);
    else if (is_wr) d2 = TW'(cfg.prog_dly);
    else            d2 = TW'(cfg.erase_dly);
  end

  always_comb begin
    ch_we = 1'b0;
    ch_wa = ch_addr;
    ch_wd = is_rd ? t2 : t1;
    cp_we = 1'b0;
    cp_wa = cp_r;
    cp_wd = t2;
    if (cmd.clear) begin
      ch_we = ({1'b0, clr_idx} < (CLR_AW+1)'(MAX_CHANNELS));
      ch_wa = CH_AW'(clr_idx);
      ch_wd = '0;
      cp_we = ({1'b0, clr_idx} < (CLR_AW+1)'(MAX_CHIPS));
      cp_wa = CP_AW'(clr_idx);
      cp_wd = '0;
    end else if (cmd.wb) begin
      ch_we = is_rd | is_wr;
      cp_we = is_rd | is_wr | is_er;
    end
  end

  always_ff @(posedge clk) begin
    if (ch_we) chan_mem[ch_wa] <= ch_wd;
    if (cmd.rd) ch_rdata <= chan_mem[ch_addr];
  end

  always_ff @(posedge clk) begin
    if (cp_we) chip_mem[cp_wa] <= cp_wd;
    if (cmd.rd) cp_rdata <= chip_mem[cp_r];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      div_cnt <= '0;
    end else begin
      if (cmd.clear) clr_idx <= clr_idx + 1'b1;
      if (cmd.accept) div_cnt <= '0;
      else if (cmd.div_step) div_cnt <= div_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= operation;
      now_r <= now_time;
      cp_r  <= CP_AW'(chip_wrap(chip_index));
      dvs   <= nch;
      rem   <= '0;
      sh    <= chip_index;
    end
    // restoring remainder, one bit of chip_index per step
    if (cmd.div_step) begin
      if (trial >= {1'b0, dvs}) rem <= NW'(trial - {1'b0, dvs});
      else                      rem <= trial[NW-1:0];
      sh <= {sh[CW-2:0], 1'b0};
    end
    if (cmd.calc1) t1 <= sat_add(a1, d1);
    if (cmd.calc2) t2 <= sat_add(b2, d2);
    if (cmd.wb) res <= (is_rd | is_wr) ? (t2 - now_r) : '0;
    if (cmd.load_out) wait_time <= res;
  end

endmodule

>>> sv/flash_channel_chip_timing_unit.sv
// Flash timing scoreboard. Each command word (operation, chip_index, now_time)
// reserves time on the chip's channel (chip_index mod channel_count) and on
// the chip itself, and returns one result word: wait_time, the ns from
// now_time until the read or write completes, 0 for an erase or the unused
// operation code. Times saturate at 2^63-1. Commands are processed one at a
// time: after acceptance a word passes through a serial remainder for the
// channel number, one bit of chip_index per step, the registered reads of
// the two time stores, 2 compare-and-add stages, a write-back and the output
// load into the result register, which waits until the output register is
// free; the next word can be accepted once that load is done. in_stall is high
// whenever a command is in flight. A finished result waits in the output
// register, and the next command is accepted while it waits. After reset the
// unit zeroes both time stores, one entry a cycle, walking an index through
// max(MAX_CHANNELS, MAX_CHIPS) entries (64 by default) and stalls input until
// done; APB writes are taken throughout. Registers sit at byte address 4*i:
// channel count, write transfer delay, program delay, cell read delay, read
// transfer delay, erase delay; change them only while no command is in
// flight.
module flash_channel_chip_timing_unit #(
  parameter int MAX_CHANNELS = fcct_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_CHIPS    = fcct_pkg::DEF_MAX_CHIPS
) (
  input  logic                          clk,
  input  logic                          rst,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fcct_pkg::APB_AW-1:0]   paddr,
  input  logic [fcct_pkg::APB_DW-1:0]   pwdata,
  output logic [fcct_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  // command words
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [fcct_pkg::OP_W-1:0]     operation,
  input  logic [fcct_pkg::CHIP_W-1:0]   chip_index,
  input  logic [fcct_pkg::TIME_W-1:0]   now_time,
  // result words
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fcct_pkg::TIME_W-1:0]   wait_time
);

  fcct_pkg::cfg_t cfg;
  fcct_pkg::cmd_t cmd;
  fcct_pkg::sts_t sts;

  // register file
  fcct_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: clear sweep, accept, remainder, read, two reservations,
  // write-back, output handoff
  fcct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // time stores and arithmetic
  fcct_dpath #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_CHIPS    (MAX_CHIPS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .sts        (sts),
    .operation  (operation),
    .chip_index (chip_index),
    .now_time   (now_time),
    .wait_time  (wait_time)
  );

endmodule

>>> dv/tb_flash_channel_chip_timing_unit.sv
module tb_flash_channel_chip_timing_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // Hard stop, set far above the length of a correct run even with the heavy
  // stall phases, so it leaves a wide margin.
  localparam int CYCLE_LIMIT = 500000;
  localparam int WORDS_PER_PHASE = 150;
  localparam int NUM_PHASES = 6;
  localparam logic [fcct_pkg::TIME_W-1:0] TIME_TOP = {fcct_pkg::TIME_W{1'b1}};

  // ---------------------------------------------------------------------------
  // Timing scoreboard: keeps its own copy of the timing registers and of the
  // channel and chip next-free times, works out wait_time for every accepted
  // command word and matches result words against it in order.
  // ---------------------------------------------------------------------------
  class wait_time_board;
    logic [fcct_pkg::COUNT_W-1:0] chan_count;
    logic [fcct_pkg::DLY_W-1:0]   wr_xfer_dly, prog_dly, cell_rd_dly, rd_xfer_dly, erase_dly;
    logic [fcct_pkg::TIME_W-1:0]  chan_free [fcct_pkg::DEF_MAX_CHANNELS];
    logic [fcct_pkg::TIME_W-1:0]  chip_free [fcct_pkg::DEF_MAX_CHIPS];
    logic [fcct_pkg::TIME_W-1:0]  waits_due [$];
    int errors;
    int words_checked;
    int settings;
    int op_seen [4];

    function new();
      chan_count  = fcct_pkg::RST_CHANNEL_COUNT;
      wr_xfer_dly = fcct_pkg::RST_WRITE_XFER;
      prog_dly    = fcct_pkg::RST_PROGRAM;
      cell_rd_dly = fcct_pkg::RST_CELL_READ;
      rd_xfer_dly = fcct_pkg::RST_READ_XFER;
      erase_dly   = fcct_pkg::RST_ERASE;
      foreach (chan_free[i]) chan_free[i] = '0;
      foreach (chip_free[i]) chip_free[i] = '0;
      foreach (op_seen[i]) op_seen[i] = 0;
      errors = 0;
      words_checked = 0;
      settings = 0;
    endfunction

    function void set_reg(logic [fcct_pkg::REG_W-1:0] idx,
                          logic [fcct_pkg::APB_DW-1:0] val);
      case (idx)
        fcct_pkg::REG_CHANNEL_COUNT: chan_count  = val[fcct_pkg::COUNT_W-1:0];
        fcct_pkg::REG_WRITE_XFER:    wr_xfer_dly = val;
        fcct_pkg::REG_PROGRAM:       prog_dly    = val;
        fcct_pkg::REG_CELL_READ:     cell_rd_dly = val;
        fcct_pkg::REG_READ_XFER:     rd_xfer_dly = val;
        fcct_pkg::REG_ERASE:         erase_dly   = val;
        default: ;
      endcase
    endfunction

    // time + delay, clamped at 2^63-1
    function logic [fcct_pkg::TIME_W-1:0] sat_add(logic [fcct_pkg::TIME_W-1:0] a,
                                                  logic [fcct_pkg::TIME_W-1:0] b);
      logic [fcct_pkg::TIME_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[fcct_pkg::TIME_W] ? TIME_TOP : s[fcct_pkg::TIME_W-1:0];
    endfunction

    function logic [fcct_pkg::TIME_W-1:0] later(logic [fcct_pkg::TIME_W-1:0] a,
                                                logic [fcct_pkg::TIME_W-1:0] b);
      return (a > b) ? a : b;
    endfunction

    // Books the command on its channel and chip, returns the wait until done.
    function logic [fcct_pkg::TIME_W-1:0] reserve_and_wait(
        logic [fcct_pkg::OP_W-1:0] op,
        logic [fcct_pkg::CHIP_W-1:0] chip,
        logic [fcct_pkg::TIME_W-1:0] now);
      int nch;
      int ch;
      int cp;
      logic [fcct_pkg::TIME_W-1:0] start;
      nch = chan_count;
      if (nch == 0) nch = 1;
      if (nch > fcct_pkg::DEF_MAX_CHANNELS) nch = fcct_pkg::DEF_MAX_CHANNELS;
      ch = int'(chip) % nch;
      cp = int'(chip) % fcct_pkg::DEF_MAX_CHIPS;
      case (op)
        fcct_pkg::OP_READ: begin
          // cell read on the chip, then transfer on the channel; chip held
          // until the transfer ends
          chip_free[cp] = sat_add(later(now, chip_free[cp]), cell_rd_dly);
          chan_free[ch] = sat_add(later(chip_free[cp], chan_free[ch]), rd_xfer_dly);
          chip_free[cp] = chan_free[ch];
          return chan_free[ch] - now;
        end
        fcct_pkg::OP_WRITE: begin
          chan_free[ch] = sat_add(later(now, chan_free[ch]), wr_xfer_dly);
          chip_free[cp] = sat_add(later(chan_free[ch], chip_free[cp]), prog_dly);
          return chip_free[cp] - now;
        end
        fcct_pkg::OP_ERASE: begin
          // waits for channel and chip, holds only the chip
          start = later(now, chan_free[ch]);
          chip_free[cp] = sat_add(later(start, chip_free[cp]), erase_dly);
          return '0;
        end
        default: return '0;
      endcase
    endfunction

    function void note_command(logic [fcct_pkg::OP_W-1:0] op,
                               logic [fcct_pkg::CHIP_W-1:0] chip,
                               logic [fcct_pkg::TIME_W-1:0] now);
      op_seen[op]++;
      waits_due.push_back(reserve_and_wait(op, chip, now));
    endfunction

    function void check_wait(logic [fcct_pkg::TIME_W-1:0] actual);
      logic [fcct_pkg::TIME_W-1:0] exp_wait;
      if (waits_due.size() == 0) begin
        $error("wait_time: no word expected, got %0d", actual);
        errors++;
        return;
      end
      exp_wait = waits_due.pop_front();
      words_checked++;
      if (actual !== exp_wait) begin
        $error("wait_time: expected %0d, got %0d", exp_wait, actual);
        errors++;
      end
    endfunction

    function int pending();
      return waits_due.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [fcct_pkg::APB_AW-1:0]     paddr = '0;
  logic [fcct_pkg::APB_DW-1:0]     pwdata = '0;
  logic [fcct_pkg::APB_DW-1:0]     prdata;
  logic                            pready;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [fcct_pkg::OP_W-1:0]       operation = fcct_pkg::OP_READ;
  logic [fcct_pkg::CHIP_W-1:0]     chip_index = '0;
  logic [fcct_pkg::TIME_W-1:0]     now_time = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [fcct_pkg::TIME_W-1:0]     wait_time;

  flash_channel_chip_timing_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .chip_index (chip_index),
    .now_time   (now_time),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .wait_time  (wait_time)
  );

  wait_time_board board = new();

  // idle rates in percent per cycle, changed per phase by the stimulus
  int send_idle_pct = 13;
  int recv_stall_pct = 59;
  int cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words outstanding", cycles, board.pending());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: take a word whenever out_valid is seen with our stall low,
  // then pick the next stall value at random.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_wait(wait_time);
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Drive tasks
  // ---------------------------------------------------------------------------

  // Geometric run of idle cycles; capped so the worst case stays bounded.
  function automatic int idle_run(int pct);
    int n;
    n = 0;
    while (n < 40 && $urandom_range(0, 99) < pct) n++;
    return n;
  endfunction

  // One command word. valid stays high into the next word when there is no
  // gap, so it gets a single assignment per edge either way.
  task automatic send_word(input logic [fcct_pkg::OP_W-1:0] op,
                           input logic [fcct_pkg::CHIP_W-1:0] chip,
                           input logic [fcct_pkg::TIME_W-1:0] t);
    int gap;
    gap = idle_run(send_idle_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    chip_index <= chip;
    now_time   <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_command(op, chip, t);
  endtask

  // Drop valid and wait for every outstanding result word.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  // APB write: setup then access; the select stays up between back-to-back
  // writes and is dropped once by apb_release.
  task automatic write_reg(input logic [fcct_pkg::REG_W-1:0] idx,
                           input logic [fcct_pkg::APB_DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.set_reg(idx, val);
  endtask

  task automatic apb_release();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Reprogram all six registers; only ever done with the pipe empty.
  task automatic set_timing(input logic [fcct_pkg::APB_DW-1:0] cnt,
                            input logic [fcct_pkg::APB_DW-1:0] wr,
                            input logic [fcct_pkg::APB_DW-1:0] prg,
                            input logic [fcct_pkg::APB_DW-1:0] crd,
                            input logic [fcct_pkg::APB_DW-1:0] rrd,
                            input logic [fcct_pkg::APB_DW-1:0] ers);
    hold_until_drained();
    write_reg(fcct_pkg::REG_CHANNEL_COUNT, cnt);
    write_reg(fcct_pkg::REG_WRITE_XFER, wr);
    write_reg(fcct_pkg::REG_PROGRAM, prg);
    write_reg(fcct_pkg::REG_CELL_READ, crd);
    write_reg(fcct_pkg::REG_READ_XFER, rrd);
    write_reg(fcct_pkg::REG_ERASE, ers);
    apb_release();
    board.settings++;
  endtask

  // Directed words: field extremes, every opcode, saturation, the unused
  // opcode, channel count of zero and above the table size.
  task automatic directed_words();
    send_word(fcct_pkg::OP_READ,  6'd0,  '0);
    send_word(fcct_pkg::OP_WRITE, 6'd0,  '0);
    send_word(fcct_pkg::OP_ERASE, 6'd0,  '0);
    send_word(fcct_pkg::OP_NONE,  6'd0,  '0);
    send_word(fcct_pkg::OP_READ,  6'd63, TIME_TOP);
    send_word(fcct_pkg::OP_WRITE, 6'd63, TIME_TOP);
    send_word(fcct_pkg::OP_ERASE, 6'd63, TIME_TOP);
    send_word(fcct_pkg::OP_NONE,  6'd63, TIME_TOP);
    send_word(fcct_pkg::OP_READ,  6'd8,  63'd12345);   // same channel as chip 0
    send_word(fcct_pkg::OP_WRITE, 6'd1,  '0);
    // zero channel count -> one channel; largest delays drive sums to the top
    set_timing(32'd0, '1, '1, '1, '1, '1);
    send_word(fcct_pkg::OP_READ,  6'd5,  TIME_TOP - 63'h7FFF_FFFF);
    send_word(fcct_pkg::OP_WRITE, 6'd17, TIME_TOP - 63'd1);
    send_word(fcct_pkg::OP_ERASE, 6'd33, '0);
    send_word(fcct_pkg::OP_READ,  6'd42, '0);
    // count above the table clamps to 16; zero delays
    set_timing(32'd31, '0, '0, '0, '0, '0);
    send_word(fcct_pkg::OP_READ,  6'd63, '0);
    send_word(fcct_pkg::OP_WRITE, 6'd31, 63'd1);
    send_word(fcct_pkg::OP_ERASE, 6'd47, 63'd2);
    send_word(fcct_pkg::OP_NONE,  6'd12, TIME_TOP);
  endtask

  // One random phase. Mostly well-formed traffic: a running clock that
  // creeps forward slower than the delays so channels and chips collide,
  // plus some noise words with an arbitrary now_time or the unused opcode.
  task automatic random_phase(input int p);
    logic [fcct_pkg::TIME_W-1:0] cur;
    logic [fcct_pkg::TIME_W-1:0] t;
    logic [fcct_pkg::OP_W-1:0]   op;
    logic [63:0]                 raw;
    int unsigned                 step_max;
    int                          roll;
    raw = {$urandom, $urandom};
    cur = '0;
    step_max = 400;
    case (p)
      0: set_timing(32'd8, $urandom_range(0, 3000), $urandom_range(0, 3000),
                    $urandom_range(0, 3000), $urandom_range(0, 3000),
                    $urandom_range(0, 3000));
      1: begin
        set_timing($urandom_range(1, 16), fcct_pkg::RST_WRITE_XFER,
                   fcct_pkg::RST_PROGRAM, fcct_pkg::RST_CELL_READ,
                   fcct_pkg::RST_READ_XFER, fcct_pkg::RST_ERASE);
        cur = {23'd0, raw[39:0]};
        step_max = 20000;
      end
      2: begin
        set_timing(32'd16, $urandom, $urandom, $urandom, $urandom, $urandom);
        cur = raw[fcct_pkg::TIME_W-1:0];
        step_max = 32'hFFFF_FFFF;
      end
      3: begin
        set_timing(32'd1, '0, '0, '0, '0, '0);
        step_max = 3;
      end
      4: begin
        set_timing($urandom_range(17, 31), $urandom_range(0, 1000),
                   $urandom_range(0, 1000), $urandom_range(0, 1000),
                   $urandom_range(0, 1000), $urandom_range(0, 1000));
        cur = {15'd0, raw[47:0]};
        step_max = 200;
      end
      default: begin
        // near the top of the time range with the largest delays
        set_timing(32'd0, '1, '1, '1, '1, '1);
        cur = TIME_TOP - 63'h0000_000F_FFFF_FFFF;
        step_max = 32'h0010_0000;
      end
    endcase
    for (int i = 0; i < WORDS_PER_PHASE; i++) begin
      roll = $urandom_range(0, 99);
      cur = cur + $urandom_range(0, step_max);
      case ($urandom_range(0, 2))
        0: op = fcct_pkg::OP_READ;
        1: op = fcct_pkg::OP_WRITE;
        default: op = fcct_pkg::OP_ERASE;
      endcase
      if (roll < 5) op = fcct_pkg::OP_NONE;
      raw = {$urandom, $urandom};
      t = (roll >= 92) ? raw[fcct_pkg::TIME_W-1:0] : cur;
      send_word(op, 6'($urandom_range(0, 63)), t);
      // source holds off mid-phase until everything has come back
      if (i == WORDS_PER_PHASE / 2) hold_until_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // idle mix per phase: source-light/sink-heavy, then swapped, then none
    directed_words();
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 2) begin
        send_idle_pct = 13;
        recv_stall_pct = 59;
      end else if (p < 4) begin
        send_idle_pct = 59;
        recv_stall_pct = 13;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      random_phase(p);
    end
    hold_until_drained();
    repeat (30) @(posedge clk);
    $display("Commands: %0d read, %0d write, %0d erase, %0d unused opcode",
             board.op_seen[fcct_pkg::OP_READ], board.op_seen[fcct_pkg::OP_WRITE],
             board.op_seen[fcct_pkg::OP_ERASE], board.op_seen[fcct_pkg::OP_NONE]);
    $display("%0d result words checked over %0d register settings, %0d errors",
             board.words_checked, board.settings, board.errors);
    if (board.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/fcct_pkg.sv
sv/fcct_regs.sv
sv/fcct_ctrl.sv
sv/fcct_dpath.sv
sv/flash_channel_chip_timing_unit.sv
dv/tb_flash_channel_chip_timing_unit.sv
